// ===== rtl/core/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Character codes, status codes, sequencer states and the control structs
// that pass between the sequencer and the iterative arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  // Character codes that carry meaning.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIVZERO   = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_FOLD,
    S_WAIT,
    S_AFTER,
    S_DONE
  } state_e;

  // What the sequencer does once the pending literal is folded.
  typedef enum logic [2:0] {
    OPK_ADD,
    OPK_SUB,
    OPK_MUL,
    OPK_DIV,
    OPK_END
  } op_kind_e;

  // Multiplicative operator waiting for its right operand.
  typedef enum logic [1:0] {
    MOP_NONE,
    MOP_MUL,
    MOP_DIV
  } mul_op_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/iee_in_if.sv =====
// ----------------------------------------------------------------------------
// iee_in_if: character request channel
// Carries one expression character and its end-of-expression flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iee_out_if.sv =====
// ----------------------------------------------------------------------------
// iee_out_if: result request channel
// Carries the value and status of one finished expression.
// ----------------------------------------------------------------------------
`default_nettype none

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/iee_alu.sv =====
// ----------------------------------------------------------------------------
// iee_alu: iterative multiply and signed divide unit
// One bit per cycle through a single shared adder.
// Multiply keeps the low WIDTH bits; divide truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_alu #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire iee_pkg::alu_req_t  req_i,
  input  wire logic [WIDTH-1:0]   a_i,
  input  wire logic [WIDTH-1:0]   b_i,
  output iee_pkg::alu_rsp_t       rsp_o,
  output logic [WIDTH-1:0]        result_o
);

  localparam int CW = $clog2(WIDTH);
  localparam int AW = WIDTH + 2;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             div_q, div_d;
  logic             neg_q, neg_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] acc_q, acc_d;

  logic             na, nb;
  logic [WIDTH-1:0] ma, mb;
  logic [AW-1:0]    add_x, add_y, add_s;
  logic             add_sub;

  assign na = a_i[WIDTH-1];
  assign nb = b_i[WIDTH-1];
  assign ma = na ? (~a_i + WIDTH'(1)) : a_i;
  assign mb = nb ? (~b_i + WIDTH'(1)) : b_i;

  // Shared adder: accumulate for multiply, trial subtract for divide.
  always_comb begin
    if (div_q) begin
      add_x   = AW'({acc_q, a_q[WIDTH-1]});
      add_y   = AW'(b_q);
      add_sub = 1'b1;
    end else begin
      add_x   = AW'(acc_q);
      add_y   = AW'(a_q);
      add_sub = 1'b0;
    end
    add_s = add_x + (add_sub ? ~add_y : add_y) + AW'(add_sub);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH - 1);
      div_d  = req_i.is_div;
      neg_d  = na ^ nb;
      acc_d  = '0;
      if (req_i.is_div) begin
        a_d = ma;
        b_d = mb;
      end else begin
        a_d = a_i;
        b_d = b_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        if (!add_s[AW-1]) begin
          acc_d = add_s[WIDTH-1:0];
          a_d   = {a_q[WIDTH-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[WIDTH-2:0], a_q[WIDTH-1]};
          a_d   = {a_q[WIDTH-2:0], 1'b0};
        end
      end else begin
        if (b_q[0]) begin
          acc_d = add_s[WIDTH-1:0];
        end
        a_d = {a_q[WIDTH-2:0], 1'b0};
        b_d = {1'b0, b_q[WIDTH-1:1]};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      div_q  <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign result_o   = div_q ? (neg_q ? (~a_q + WIDTH'(1)) : a_q) : acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator: character-serial integer expression evaluator
// Folds digits and + - * / into a value with * and / bound before + and -.
// ----------------------------------------------------------------------------
// Usage: characters arrive one request at a time on req_i (char_code plus
// last_char). Digits extend the current literal, operators fold it, and all
// other characters are ignored. The request with last_char set closes the
// expression, and one result (value, status) leaves on rsp_o.
// Sequence: a digit or an ignored character is taken in S_IDLE. An operator
// passes S_FOLD and S_AFTER and waits in S_WAIT when it folds a multiply or
// divide, since the shared shift-add and restoring divide unit retires one
// bit per cycle. Closing passes S_CLOSE, the same fold states for a pending
// literal, and then S_DONE.
// The result sits in an output register; while the receiver stalls the block
// keeps taking characters and waits only when it has a new result to place.
// Reset clears the expression state and drops any result not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator #(
  parameter int WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iee_in_if.sink    req_i,
  iee_out_if.source rsp_o
);

  iee_pkg::state_e   state_q, state_d;
  iee_pkg::op_kind_e opk_q, opk_d;
  iee_pkg::mul_op_e  mop_q, mop_d;

  logic [WIDTH-1:0] lit_q, lit_d;
  logic             pend_q, pend_d;
  logic [WIDTH-1:0] term_q, term_d;
  logic             tv_q, tv_d;
  logic [WIDTH-1:0] sum_q, sum_d;
  logic             minus_q, minus_d;
  logic [1:0]       err_q, err_d;
  logic             last_q, last_d;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_value_q, out_value_d;
  logic [1:0]         out_status_q, out_status_d;

  logic                 accept, is_digit, is_op, out_free, fold_start, lit_ovf;
  logic [3:0]           digit;
  logic [WIDTH+3:0]     lit10;
  logic signed [WIDTH-1:0] sum_s;
  iee_pkg::op_kind_e    char_kind;
  iee_pkg::alu_req_t    alu_req;
  iee_pkg::alu_rsp_t    alu_rsp;
  logic [WIDTH-1:0]     alu_result;

  assign accept   = req_i.valid && req_i.ready;
  assign is_digit = (req_i.char_code >= iee_pkg::CHAR_ZERO) &&
                    (req_i.char_code <= iee_pkg::CHAR_NINE);
  assign is_op    = (req_i.char_code == iee_pkg::CHAR_PLUS) ||
                    (req_i.char_code == iee_pkg::CHAR_MINUS) ||
                    (req_i.char_code == iee_pkg::CHAR_STAR) ||
                    (req_i.char_code == iee_pkg::CHAR_SLASH);
  assign digit    = 4'(req_i.char_code - iee_pkg::CHAR_ZERO);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign sum_s    = sum_q;

  // literal * 10 + digit; anything at or above the sign bit overflows.
  assign lit10   = ({4'b0, lit_q} << 3) + ({4'b0, lit_q} << 1) + (WIDTH+4)'(digit);
  assign lit_ovf = (lit10[WIDTH+3:WIDTH-1] != '0);

  // A multiply, or a divide by a nonzero literal, needs the iterative unit.
  assign fold_start = tv_q && ((mop_q == iee_pkg::MOP_MUL) ||
                               ((mop_q == iee_pkg::MOP_DIV) && (lit_q != '0)));

  always_comb begin
    case (req_i.char_code)
      iee_pkg::CHAR_PLUS:  char_kind = iee_pkg::OPK_ADD;
      iee_pkg::CHAR_MINUS: char_kind = iee_pkg::OPK_SUB;
      iee_pkg::CHAR_STAR:  char_kind = iee_pkg::OPK_MUL;
      default:             char_kind = iee_pkg::OPK_DIV;
    endcase
  end

  iee_alu #(
    .WIDTH (WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (term_q),
    .b_i      (lit_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      iee_pkg::S_IDLE: begin
        if (accept) begin
          if (is_op && pend_q) begin
            state_d = iee_pkg::S_FOLD;
          end else if (req_i.last_char) begin
            state_d = iee_pkg::S_CLOSE;
          end
        end
      end
      iee_pkg::S_CLOSE: begin
        state_d = pend_q ? iee_pkg::S_FOLD : iee_pkg::S_DONE;
      end
      iee_pkg::S_FOLD: begin
        state_d = fold_start ? iee_pkg::S_WAIT : iee_pkg::S_AFTER;
      end
      iee_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          state_d = iee_pkg::S_AFTER;
        end
      end
      iee_pkg::S_AFTER: begin
        if (opk_q == iee_pkg::OPK_END) begin
          state_d = iee_pkg::S_DONE;
        end else if (last_q) begin
          state_d = iee_pkg::S_CLOSE;
        end else begin
          state_d = iee_pkg::S_IDLE;
        end
      end
      iee_pkg::S_DONE: begin
        if (out_free) begin
          state_d = iee_pkg::S_IDLE;
        end
      end
      default: state_d = iee_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    opk_d        = opk_q;
    mop_d        = mop_q;
    lit_d        = lit_q;
    pend_d       = pend_q;
    term_d       = term_q;
    tv_d         = tv_q;
    sum_d        = sum_q;
    minus_d      = minus_q;
    err_d        = err_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    alu_req      = '0;
    case (state_q)
      iee_pkg::S_IDLE: begin
        if (accept) begin
          last_d = req_i.last_char;
          if (is_digit) begin
            pend_d = 1'b1;
            if (lit_ovf) begin
              if (err_q == iee_pkg::ST_OK) err_d = iee_pkg::ST_OVERFLOW;
            end else begin
              lit_d = lit10[WIDTH-1:0];
            end
          end else if (is_op) begin
            if (!pend_q) begin
              if (err_q == iee_pkg::ST_OK) err_d = iee_pkg::ST_MALFORMED;
            end else begin
              opk_d = char_kind;
            end
          end
        end
      end
      iee_pkg::S_CLOSE: begin
        if (!pend_q) begin
          if (err_q == iee_pkg::ST_OK) err_d = iee_pkg::ST_MALFORMED;
        end else begin
          opk_d = iee_pkg::OPK_END;
        end
      end
      iee_pkg::S_FOLD: begin
        lit_d  = '0;
        pend_d = 1'b0;
        tv_d   = 1'b1;
        if (!tv_q || (mop_q == iee_pkg::MOP_NONE)) begin
          term_d = lit_q;
        end else if (fold_start) begin
          alu_req.start  = 1'b1;
          alu_req.is_div = (mop_q == iee_pkg::MOP_DIV);
        end else begin
          // Divide by zero: the dividend stays as the term.
          if (err_q == iee_pkg::ST_OK) err_d = iee_pkg::ST_DIVZERO;
        end
      end
      iee_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          term_d = alu_result;
        end
      end
      iee_pkg::S_AFTER: begin
        case (opk_q)
          iee_pkg::OPK_MUL: mop_d = iee_pkg::MOP_MUL;
          iee_pkg::OPK_DIV: mop_d = iee_pkg::MOP_DIV;
          default: begin
            sum_d   = minus_q ? (sum_q - term_q) : (sum_q + term_q);
            term_d  = '0;
            tv_d    = 1'b0;
            mop_d   = iee_pkg::MOP_NONE;
            minus_d = (opk_q == iee_pkg::OPK_SUB);
          end
        endcase
      end
      iee_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = (err_q == iee_pkg::ST_OK) ? 32'(sum_s) : '0;
          out_status_d = err_q;
          lit_d        = '0;
          pend_d       = 1'b0;
          term_d       = '0;
          tv_d         = 1'b0;
          mop_d        = iee_pkg::MOP_NONE;
          sum_d        = '0;
          minus_d      = 1'b0;
          err_d        = iee_pkg::ST_OK;
          last_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::S_IDLE;
      opk_q       <= iee_pkg::OPK_ADD;
      mop_q       <= iee_pkg::MOP_NONE;
      lit_q       <= '0;
      pend_q      <= 1'b0;
      term_q      <= '0;
      tv_q        <= 1'b0;
      sum_q       <= '0;
      minus_q     <= 1'b0;
      err_q       <= iee_pkg::ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      opk_q       <= opk_d;
      mop_q       <= mop_d;
      lit_q       <= lit_d;
      pend_q      <= pend_d;
      term_q      <= term_d;
      tv_q        <= tv_d;
      sum_q       <= sum_d;
      minus_q     <= minus_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign req_i.ready  = (state_q == iee_pkg::S_IDLE);
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.value  = out_value_q;
  assign rsp_o.status = out_status_q;

  // The sequencer only waits while the unit is working or reporting.
  a_wait_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iee_pkg::S_WAIT) |-> (alu_rsp.busy || alu_rsp.done))
    else $error("waiting on an idle arithmetic unit");

  // Issuing a result returns the expression state to its reset values.
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == iee_pkg::S_DONE) && out_free) |=>
      (!pend_q && !tv_q && (sum_q == '0) && (err_q == iee_pkg::ST_OK)))
    else $error("expression state not cleared after result");

  // Any error status comes with a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != iee_pkg::ST_OK)) |-> (out_value_q == '0))
    else $error("nonzero value with error status");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the infix expression evaluator
// Streams directed and random expressions into the block one character per
// request. A local model of the evaluator computes each expected result, and
// the results are checked in order under changing idle and stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int EVAL_WIDTH   = 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [31:0] LIT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [1:0]  status;
  } expr_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_EMPTY,
    FLAW_LEADING,
    FLAW_DOUBLED,
    FLAW_TRAILING
  } flaw_e;

  logic clk;
  logic rst_n;

  iee_in_if  req_if();
  iee_out_if rsp_if();

  infix_expression_evaluator #(
    .WIDTH(EVAL_WIDTH)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Local copy of the expression state.
  logic [31:0]        lit_acc;
  logic               lit_seen;
  logic [31:0]        term_acc;
  logic               term_live;
  iee_pkg::mul_op_e   mul_op;
  logic [31:0]        sum_acc;
  logic               minus_next;
  logic [1:0]         first_err;

  expr_result_t expected_results[$];
  logic [7:0]   expr_text[$];

  int src_idle_pct;
  int dst_idle_pct;
  int hold_token;
  int chars_sent;
  int exprs_sent;
  int results_checked;
  int error_count;
  int quiet_cycles;
  int status_seen[4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] trunc_div(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    mag_a = a[31] ? -a : a;
    mag_b = b[31] ? -b : b;
    quot  = mag_a / mag_b;
    if (a[31] ^ b[31]) quot = -quot;
    return quot;
  endfunction

  function void note_error(input logic [1:0] code);
    if (first_err == iee_pkg::ST_OK) first_err = code;
  endfunction

  function void clear_expression();
    lit_acc    = '0;
    lit_seen   = 1'b0;
    term_acc   = '0;
    term_live  = 1'b0;
    mul_op     = iee_pkg::MOP_NONE;
    sum_acc    = '0;
    minus_next = 1'b0;
    first_err  = iee_pkg::ST_OK;
  endfunction

  function void merge_literal();
    if (!term_live || mul_op == iee_pkg::MOP_NONE) begin
      term_acc = lit_acc;
    end else if (mul_op == iee_pkg::MOP_MUL) begin
      term_acc = term_acc * lit_acc;
    end else if (lit_acc == '0) begin
      // The dividend survives a division by zero.
      note_error(iee_pkg::ST_DIVZERO);
    end else begin
      term_acc = trunc_div(term_acc, lit_acc);
    end
    term_live = 1'b1;
    lit_acc   = '0;
    lit_seen  = 1'b0;
  endfunction

  function void merge_term();
    sum_acc   = minus_next ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc  = '0;
    term_live = 1'b0;
    mul_op    = iee_pkg::MOP_NONE;
  endfunction

  function void evaluate_char(input logic [7:0] ch, input logic last);
    logic [31:0]  digit;
    expr_result_t res;
    if (ch >= iee_pkg::CHAR_ZERO && ch <= iee_pkg::CHAR_NINE) begin
      digit = 32'(ch - iee_pkg::CHAR_ZERO);
      // An overflowing literal keeps the last value that fit.
      if (lit_acc > (LIT_MAX - digit) / 10) note_error(iee_pkg::ST_OVERFLOW);
      else lit_acc = lit_acc * 10 + digit;
      lit_seen = 1'b1;
    end else if (ch == iee_pkg::CHAR_PLUS || ch == iee_pkg::CHAR_MINUS ||
                 ch == iee_pkg::CHAR_STAR || ch == iee_pkg::CHAR_SLASH) begin
      if (!lit_seen) begin
        note_error(iee_pkg::ST_MALFORMED);
      end else begin
        merge_literal();
        if (ch == iee_pkg::CHAR_STAR) begin
          mul_op = iee_pkg::MOP_MUL;
        end else if (ch == iee_pkg::CHAR_SLASH) begin
          mul_op = iee_pkg::MOP_DIV;
        end else begin
          merge_term();
          minus_next = (ch == iee_pkg::CHAR_MINUS);
        end
      end
    end
    if (last) begin
      if (!lit_seen) begin
        note_error(iee_pkg::ST_MALFORMED);
      end else begin
        merge_literal();
        merge_term();
      end
      res.status = first_err;
      res.value  = (first_err == iee_pkg::ST_OK) ? sum_acc : '0;
      expected_results = {expected_results, res};
      clear_expression();
    end
  endfunction

  function void append_text(input logic [7:0] ch);
    expr_text = {expr_text, ch};
  endfunction

  // Spaces between digits merge them into one literal, which is intended.
  function void push_char(input logic [7:0] ch);
    append_text(ch);
    if ($urandom_range(0, 99) < 6) append_text(8'h20);
    else if ($urandom_range(0, 99) < 2) append_text(8'($urandom_range(0, 255)));
  endfunction

  function void build_random_expression();
    int         operands;
    int         ndigits;
    flaw_e      flaw;
    logic [7:0] ops[4];
    string      edge_lits[5];
    string      lit;
    ops       = '{iee_pkg::CHAR_PLUS, iee_pkg::CHAR_MINUS, iee_pkg::CHAR_STAR,
                  iee_pkg::CHAR_SLASH};
    edge_lits = '{"2147483647", "2147483648", "65536", "32768", "1"};
    expr_text.delete();
    flaw = FLAW_NONE;
    if ($urandom_range(0, 99) < 10) flaw = flaw_e'($urandom_range(FLAW_EMPTY, FLAW_TRAILING));
    if (flaw == FLAW_EMPTY) begin
      append_text(8'h20);
      return;
    end
    if (flaw == FLAW_LEADING) push_char(ops[$urandom_range(0, 3)]);
    operands = $urandom_range(1, 6);
    for (int i = 0; i < operands; i++) begin
      if (i != 0) begin
        push_char(ops[$urandom_range(0, 3)]);
        if (flaw == FLAW_DOUBLED && i == 1) push_char(ops[$urandom_range(0, 3)]);
      end
      ndigits = 0;
      case ($urandom_range(0, 9))
        0: begin
          push_char(iee_pkg::CHAR_ZERO);
        end
        1: begin
          lit = edge_lits[$urandom_range(0, 4)];
          for (int k = 0; k < lit.len(); k++) push_char(lit[k]);
        end
        2: begin
          ndigits = $urandom_range(6, 11);
        end
        default: begin
          ndigits = $urandom_range(1, 3);
        end
      endcase
      repeat (ndigits) push_char(8'(iee_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    end
    if (flaw == FLAW_TRAILING) push_char(ops[$urandom_range(0, 3)]);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.char_code <= ch;
    req_if.last_char <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    evaluate_char(ch, last);
    chars_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_text[i]) send_char(expr_text[i], i == expr_text.size() - 1);
    exprs_sent++;
  endtask

  task automatic test_directed();
    string texts[5];
    texts = '{"7 -9/2", "6*7+", "5/0*3", "*4", "2147483648"};
    // Empty expression made of a single NUL character.
    expr_text = '{8'h00};
    send_expression();
    foreach (texts[n]) begin
      expr_text.delete();
      for (int k = 0; k < texts[n].len(); k++) append_text(texts[n][k]);
      if (n == 0) expr_text.insert(1, 8'hFF);
      send_expression();
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int dst_pct, input int n_chars);
    int target;
    target       = chars_sent + n_chars;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    while (chars_sent < target) begin
      build_random_expression();
      send_expression();
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while characters keep being offered.
  task automatic test_output_stall(input int n_chars);
    int target;
    target       = chars_sent + n_chars;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    hold_token++;
    while (chars_sent < target) begin
      build_random_expression();
      send_expression();
    end
  endtask

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    expr_result_t want;
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                 $time, rsp_if.value, rsp_if.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_seen[want.status]++;
        if (rsp_if.value !== want.value) begin
          $display("%0t: value mismatch, expected %0d, actual %0d",
                   $time, want.value, rsp_if.value);
          error_count++;
        end
        if (rsp_if.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp_if.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("infix_expression_evaluator test failed");
      $finish;
    end
  end

  initial begin
    clear_expression();
    src_idle_pct = 34;
    dst_idle_pct = 46;
    hold_token   = 0;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.char_code <= '0;
    req_if.last_char <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(34, 46, 560);
    test_random_traffic(46, 34, 560);
    test_random_traffic(0, 0, 560);
    test_output_stall(150);
    req_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d expressions across three idle mixes and a long stall.",
             chars_sent, exprs_sent);
    $display("Checked %0d results: %0d ok, %0d div by zero, %0d malformed, %0d overflow.",
             results_checked, status_seen[iee_pkg::ST_OK], status_seen[iee_pkg::ST_DIVZERO],
             status_seen[iee_pkg::ST_MALFORMED], status_seen[iee_pkg::ST_OVERFLOW]);
    if (error_count == 0) begin
      $display("infix_expression_evaluator test passed");
    end else begin
      $display("infix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/iee_pkg.sv
rtl/core/iee_in_if.sv
rtl/core/iee_out_if.sv
rtl/core/iee_alu.sv
rtl/core/infix_expression_evaluator.sv
tb/tb_top.sv
